// ----- rtl/core/mrfp_pkg.sv -----
package mrfp_pkg;

    localparam int MAX_PAYLOAD = 8;
    localparam int LEN_W       = 4;
    localparam int POS_W       = 4;
    localparam int DATA_W      = 8 * MAX_PAYLOAD;
    localparam int MASK_W      = 64;
    localparam int CFG_W       = 64;

    localparam logic [7:0]       START_BYTE  = 8'h3E;
    localparam logic [POS_W-1:0] POS_CMD     = 4'd1;
    localparam logic [POS_W-1:0] POS_ID      = 4'd2;
    localparam logic [POS_W-1:0] POS_LEN     = 4'd3;
    localparam logic [POS_W-1:0] POS_HSUM    = 4'd4;
    localparam logic [POS_W-1:0] POS_DATA    = 4'd5;
    localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(MAX_PAYLOAD);

    localparam logic CFG_PAYLOAD_LENGTH = 1'b0;
    localparam logic CFG_ID_ENABLE_MASK = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LEN_ERR  = 3'd1,
        ST_HSUM_ERR = 3'd2,
        ST_PSUM_ERR = 3'd3,
        ST_UNREG_ID = 3'd4
    } t_status;

    typedef struct packed {
        logic              in_frame;
        logic [POS_W-1:0]  pos;
        logic [7:0]        cmd;
        logic [7:0]        id;
        logic [7:0]        hsum;
        logic [7:0]        psum;
        logic [DATA_W-1:0] store;
    } t_frame;

    typedef struct packed {
        t_status           status;
        logic [7:0]        node_id;
        logic [7:0]        command;
        logic [DATA_W-1:0] payload;
        logic [LEN_W-1:0]  count;
    } t_result;

    localparam t_frame FRAME_IDLE = '{
        in_frame: 1'b0, pos: '0, cmd: '0, id: '0, hsum: '0, psum: '0, store: '0
    };

endpackage

// ----- rtl/core/mrfp_step.sv -----
module mrfp_step
    import mrfp_pkg::*;
(
    input  t_frame           i_frame,
    input  logic [7:0]       i_rx_byte,
    input  logic [LEN_W-1:0] i_payload_length,
    input  logic [MASK_W-1:0] i_id_enable_mask,
    output t_frame           o_frame,
    output logic             o_emit,
    output t_result          o_result
);

    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] k;
    logic [7:0]       hsum_add;
    logic [7:0]       psum_add;
    logic             id_known;

    assign len      = (i_payload_length > LEN_MAX) ? LEN_MAX : i_payload_length;
    assign k        = i_frame.pos - POS_DATA;
    assign hsum_add = i_frame.hsum + i_rx_byte;
    assign psum_add = i_frame.psum + i_rx_byte;
    assign id_known = (i_frame.id < 8'(MASK_W)) && i_id_enable_mask[i_frame.id[5:0]];

    always_comb begin
        o_frame           = i_frame;
        o_emit            = 1'b0;
        o_result.status   = ST_OK;
        o_result.node_id  = i_frame.id;
        o_result.command  = i_frame.cmd;
        o_result.payload  = '0;
        o_result.count    = '0;

        if (!i_frame.in_frame) begin
            if (i_rx_byte == START_BYTE) begin
                o_frame.in_frame = 1'b1;
                o_frame.pos      = POS_CMD;
                o_frame.hsum     = i_rx_byte;
            end
        end else if (i_frame.pos == POS_CMD) begin
            o_frame.cmd  = i_rx_byte;
            o_frame.hsum = hsum_add;
            o_frame.pos  = POS_ID;
        end else if (i_frame.pos == POS_ID) begin
            o_frame.id   = i_rx_byte;
            o_frame.hsum = hsum_add;
            o_frame.pos  = POS_LEN;
        end else if (i_frame.pos == POS_LEN) begin
            if (i_rx_byte != 8'(len)) begin
                o_emit          = 1'b1;
                o_result.status = ST_LEN_ERR;
                o_frame         = FRAME_IDLE;
            end else begin
                o_frame.hsum = hsum_add;
                o_frame.pos  = POS_HSUM;
            end
        end else if (i_frame.pos == POS_HSUM) begin
            if (i_rx_byte != i_frame.hsum) begin
                o_emit          = 1'b1;
                o_result.status = ST_HSUM_ERR;
                o_frame         = FRAME_IDLE;
            end else begin
                o_frame.pos = POS_DATA;
            end
        end else if (k < len) begin
            for (int j = 0; j < MAX_PAYLOAD; j++) begin
                if (k[2:0] == 3'(j)) begin
                    o_frame.store[j*8 +: 8] = i_frame.store[j*8 +: 8] | i_rx_byte;
                end
            end
            o_frame.psum = psum_add;
            o_frame.pos  = i_frame.pos + 1'b1;
        end else begin
            o_emit  = 1'b1;
            o_frame = FRAME_IDLE;
            if (i_rx_byte != i_frame.psum) begin
                o_result.status = ST_PSUM_ERR;
            end else if (!id_known) begin
                o_result.status = ST_UNREG_ID;
            end else begin
                o_result.status  = ST_OK;
                o_result.payload = i_frame.store;
                o_result.count   = k;
            end
        end
    end

endmodule

// ----- rtl/core/motor_reply_frame_parser.sv -----
// Motor reply frame parser: takes one received word per cycle, hunts for the
// start byte 0x3E and checks length, header sum, payload sum and id enable, giving one
// result word per frame or at the first error. A word is taken every cycle
// while the result register is empty or being read; a result appears in the
// cycle after the word that closes the frame and holds until taken, and only
// then does a stalled result hold off input. Frames may have any number of
// idle cycles between words. Write configuration only while no frame is open.
module motor_reply_frame_parser
    import mrfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [7:0]        o_node_id,
    output logic [7:0]        o_command,
    output logic [DATA_W-1:0] o_payload,
    output logic [LEN_W-1:0]  o_payload_count
);

    logic [LEN_W-1:0]  r_payload_length;
    logic [MASK_W-1:0] r_id_enable_mask;
    t_frame            r_frame;
    t_frame            n_frame;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;
    logic              n_emit;
    logic              accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    mrfp_step u_step (
        .i_frame          (r_frame),
        .i_rx_byte        (i_rx_byte),
        .i_payload_length (r_payload_length),
        .i_id_enable_mask (r_id_enable_mask),
        .o_frame          (n_frame),
        .o_emit           (n_emit),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= LEN_RESET;
            r_id_enable_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAYLOAD_LENGTH: r_payload_length <= i_cfg_data[LEN_W-1:0];
                CFG_ID_ENABLE_MASK: r_id_enable_mask <= i_cfg_data[MASK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= FRAME_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_frame <= n_frame;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_result.status;
    assign o_node_id       = r_result.node_id;
    assign o_command       = r_result.command;
    assign o_payload       = r_result.payload;
    assign o_payload_count = r_result.count;

endmodule

// ----- rtl/core/mrfp_checker.sv -----
module mrfp_checker
    import mrfp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [2:0]        o_status,
    input logic [DATA_W-1:0] o_payload,
    input logic [LEN_W-1:0]  o_payload_count
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_payload == '0) && (o_payload_count == '0))
        else $error("payload on error result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_count <= LEN_W'(MAX_PAYLOAD))
            && (o_status <= 3'(ST_UNREG_ID)))
        else $error("result fields out of range");

    // an empty result register never blocks input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no result pending");

endmodule

bind motor_reply_frame_parser mrfp_checker u_mrfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_payload       (o_payload),
    .o_payload_count (o_payload_count)
);
